// ===== rtl/core/sha_pkg.sv =====
// SHA-256 stream hasher package: round constants, initial hash value,
// round functions, state and control types. Used by the top level and sha_core.
// Depends on nothing.
package sha_pkg;

    // Round constants, one per compression round.
    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Initial hash value.
    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [1:0] PART_LAST  = 2'd3;
    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [7:0] ZERO_BYTE  = 8'h00;
    localparam int unsigned COUNT_W   = 61;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PAD  = 4'b0010,
        S_COMP = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    // Commands from the sequencer to the compression core.
    typedef struct packed {
        logic       push;
        logic [7:0] push_byte;
        logic       start;
        logic       reinit;
    } t_core_ctl;

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

// ===== rtl/core/sha_in_if.sv =====
// Message input channel: one byte beat with presence and end marker.
// Depends on nothing.
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, output data_byte, output byte_present,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input byte_present,
                    input end_of_message, output ready);
endinterface

// ===== rtl/core/sha_out_if.sv =====
// Digest output channel: one 64-bit quarter of the digest per beat.
// Depends on nothing.
interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_part;
    logic [1:0]  part_index;
    logic        last_part;

    modport source (output valid, output digest_part, output part_index,
                    output last_part, input ready);
    modport sink   (input valid, input digest_part, input part_index,
                    input last_part, output ready);
endinterface

// ===== rtl/core/sha256_stream_hasher.sv =====
// SHA-256 stream hasher top level: byte sequencer, padding and digest output.
// Depends on sha_pkg, sha_in_if, sha_out_if and sha_core.
//
// Usage: message bytes arrive one per beat on i_msg. A beat with
// byte_present low carries no byte; end_of_message marks the last beat of a
// message, so a lone end beat with no byte hashes the empty message.
// The digest leaves on o_dig as four 64-bit beats, part 0 first (hash words
// 0 and 1), last_part high on part 3; the block then starts a new message.
// Flow: a byte beat is taken while ready is high and the 64-byte window fills.
// The 64th byte of a block starts the compression, which keeps ready low
// through the rounds of the single round unit and the hash add (the working
// registers load on the edge that takes the byte). After the end beat the
// padding is shifted in one byte per cycle (plus a second compression when
// more than 55 bytes are pending), then the final compression runs and the
// digest beats follow. The round unit sets the throughput.
// Reset (synchronous, active low) restores the initial hash value and clears
// the fill and length counters. When the receiver stalls, the current digest
// beat holds and no new message byte is taken until all four are delivered.
module sha256_stream_hasher import sha_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sha_in_if.sink     i_msg,
    sha_out_if.source  o_dig
);

    t_state              r_state, n_state;
    logic [5:0]          r_fill, n_fill;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic                r_pad_mode, n_pad_mode;
    logic                r_pad_first, n_pad_first;
    logic                r_final, n_final;
    logic [1:0]          r_part, n_part;

    t_core_ctl     w_ctl;
    logic          w_done;
    logic [255:0]  w_hash;
    logic          w_in_acc;
    logic          w_out_acc;
    logic [63:0]   w_bits;
    logic [2:0]    w_len_idx;
    logic [7:0]    w_len_byte;

    sha_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_done  (w_done),
        .o_hash  (w_hash)
    );

    assign w_in_acc  = i_msg.valid && i_msg.ready;
    assign w_out_acc = o_dig.valid && o_dig.ready;

    // Length field: bit count, big-endian in the last eight bytes of a block.
    assign w_bits     = {r_count, 3'b000};
    assign w_len_idx  = ~r_fill[2:0];
    assign w_len_byte = w_bits[{w_len_idx, 3'b000} +: 8];

    // Sequencer: byte intake, padding, compression and digest beats.
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_count     = r_count;
        n_pad_mode  = r_pad_mode;
        n_pad_first = r_pad_first;
        n_final     = r_final;
        n_part      = r_part;
        w_ctl       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_msg.byte_present) begin
                        w_ctl.push      = 1'b1;
                        w_ctl.push_byte = i_msg.data_byte;
                        n_fill          = r_fill + 6'd1;
                        n_count         = r_count + 61'd1;
                    end
                    if (i_msg.end_of_message) begin
                        n_pad_mode  = 1'b1;
                        n_pad_first = 1'b1;
                        n_final     = 1'b0;
                    end
                    if (i_msg.byte_present && r_fill == FILL_LAST) begin
                        w_ctl.start = 1'b1;
                        n_state     = S_COMP;
                    end else if (i_msg.end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                w_ctl.push = 1'b1;
                n_fill     = r_fill + 6'd1;
                if (r_pad_first) begin
                    // The pad byte leaves room for the length only below byte 56.
                    w_ctl.push_byte = PAD_BYTE;
                    n_pad_first     = 1'b0;
                    n_final         = (r_fill[5:3] != 3'b111);
                end else if (r_final && r_fill[5:3] == 3'b111) begin
                    w_ctl.push_byte = w_len_byte;
                end else begin
                    w_ctl.push_byte = ZERO_BYTE;
                end
                if (r_fill == FILL_LAST) begin
                    w_ctl.start = 1'b1;
                    n_state     = S_COMP;
                end
            end
            S_COMP: begin
                if (w_done) begin
                    if (!r_pad_mode) begin
                        n_state = S_IDLE;
                    end else if (r_final) begin
                        n_state = S_OUT;
                        n_part  = '0;
                    end else begin
                        n_state = S_PAD;
                        n_final = 1'b1;
                    end
                end
            end
            S_OUT: begin
                if (w_out_acc) begin
                    n_part = r_part + 2'd1;
                    if (r_part == PART_LAST) begin
                        w_ctl.reinit = 1'b1;
                        n_count      = '0;
                        n_pad_mode   = 1'b0;
                        n_state      = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_count     <= '0;
            r_pad_mode  <= 1'b0;
            r_pad_first <= 1'b0;
            r_final     <= 1'b0;
            r_part      <= '0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_count     <= n_count;
            r_pad_mode  <= n_pad_mode;
            r_pad_first <= n_pad_first;
            r_final     <= n_final;
            r_part      <= n_part;
        end
    end

    // Channel outputs; the hash registers hold while digest beats go out.
    assign i_msg.ready       = (r_state == S_IDLE);
    assign o_dig.valid       = (r_state == S_OUT);
    assign o_dig.digest_part = w_hash[{~r_part, 6'd0} +: 64];
    assign o_dig.part_index  = r_part;
    assign o_dig.last_part   = (r_part == PART_LAST);

endmodule

// ===== rtl/core/sha_core.sv =====
// SHA-256 compression core: 64-byte block window, message schedule and one
// shared round unit that runs one round per cycle. Depends on sha_pkg.
module sha_core import sha_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_core_ctl     i_ctl,
    output logic          o_done,
    output logic [255:0]  o_hash
);

    logic [31:0]  r_hash [8];
    logic [31:0]  r_work [8];
    logic [511:0] r_win;
    logic [5:0]   r_rnd;
    logic         r_busy;
    logic         r_fin;

    logic [31:0] w_wt;
    logic [31:0] w_wnew;
    logic [31:0] w_t1;
    logic [31:0] w_t2;
    logic [31:0] w_ch;
    logic [31:0] w_maj;

    // Schedule: the window holds W[t..t+15], word 0 in the top bits.
    assign w_wt   = r_win[511:480];
    assign w_wnew = small_sigma1(r_win[63:32]) + r_win[223:192]
                  + small_sigma0(r_win[479:448]) + r_win[511:480];

    // One compression round on the working variables.
    assign w_ch  = (r_work[4] & r_work[5]) ^ (~r_work[4] & r_work[6]);
    assign w_maj = (r_work[0] & r_work[1]) ^ (r_work[0] & r_work[2])
                 ^ (r_work[1] & r_work[2]);
    assign w_t1  = r_work[7] + big_sigma1(r_work[4]) + w_ch + SHA_K[r_rnd] + w_wt;
    assign w_t2  = big_sigma0(r_work[0]) + w_maj;

    // Round sequencing and hash state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_rnd  <= '0;
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= SHA_IV[i];
            end
        end else begin
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_rnd  <= '0;
            end else if (r_busy) begin
                r_rnd <= r_rnd + 6'd1;
                if (r_rnd == ROUND_LAST) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
            if (r_fin) begin
                r_fin <= 1'b0;
                for (int i = 0; i < 8; i++) begin
                    r_hash[i] <= r_hash[i] + r_work[i];
                end
            end
            if (i_ctl.reinit) begin
                for (int i = 0; i < 8; i++) begin
                    r_hash[i] <= SHA_IV[i];
                end
            end
        end
    end

    // Block window and working variables.
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_win <= {r_win[503:0], i_ctl.push_byte};
        end else if (r_busy) begin
            r_win <= {r_win[479:0], w_wnew};
        end
        if (i_ctl.start) begin
            for (int i = 0; i < 8; i++) begin
                r_work[i] <= r_hash[i];
            end
        end else if (r_busy) begin
            r_work[7] <= r_work[6];
            r_work[6] <= r_work[5];
            r_work[5] <= r_work[4];
            r_work[4] <= r_work[3] + w_t1;
            r_work[3] <= r_work[2];
            r_work[2] <= r_work[1];
            r_work[1] <= r_work[0];
            r_work[0] <= w_t1 + w_t2;
        end
    end

    assign o_done = r_fin;
    assign o_hash = {r_hash[0], r_hash[1], r_hash[2], r_hash[3],
                     r_hash[4], r_hash[5], r_hash[6], r_hash[7]};

endmodule

// ===== rtl/core/sha_checker.sv =====
// Port-level checks for the SHA-256 stream hasher and the bind that
// attaches them to the top level. Depends on sha256_stream_hasher.
module sha_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_eom,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_out_part,
    input logic [1:0]  i_out_idx,
    input logic        i_out_last
);

    // Digest beats come in order without gaps.
    a_part_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last
        |=> i_out_valid && i_out_idx == $past(i_out_idx) + 2'd1)
        else $error("digest beat out of order");

    // The last flag marks exactly the fourth beat.
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_last == (i_out_idx == 2'd3)))
        else $error("last_part does not match part_index");

    // No message byte is taken while a digest is being delivered.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while digest pending");

    // The end beat always starts padding work before the next byte.
    a_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_eom |=> !i_in_ready)
        else $error("input ready right after end of message");

    // A stalled digest beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready
        |=> i_out_valid && $stable(i_out_part) && $stable(i_out_idx))
        else $error("stalled digest beat changed");

endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_msg.valid),
    .i_in_ready  (i_msg.ready),
    .i_in_eom    (i_msg.end_of_message),
    .i_out_valid (o_dig.valid),
    .i_out_ready (o_dig.ready),
    .i_out_part  (o_dig.digest_part),
    .i_out_idx   (o_dig.part_index),
    .i_out_last  (o_dig.last_part)
);
